FILE: rtl/gaussian_decimating_fir_core_assert.svh
// Assertion macros for the Gaussian decimating FIR core.
// Used by the core files through `include; no other dependencies.
`ifndef GAUSSIAN_DECIMATING_FIR_CORE_ASSERT_SVH
`define GAUSSIAN_DECIMATING_FIR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GDF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gdf assertion failed");
`define GDF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gdf assertion failed");
`else
`define GDF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GDF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/gdf_pkg.sv
// Shared types and constants for the Gaussian decimating FIR core.
// No dependencies.
package gdf_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 18;
  localparam int DEF_MAX_RADIUS = 63;
  localparam int DEF_MAX_FACTOR = 16;
  localparam int WIN_DEPTH      = 128;
  localparam int WIN_AW         = 7;
  localparam int RESULT_CAP     = 64;
  localparam int CNT_W          = 7;
  localparam int REC_W          = 32;
  localparam int POS_W          = 34;
  localparam int FACTOR_W       = 5;
  localparam int RADIUS_W       = 6;
  localparam int COEF_IDX_W     = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 6;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = 5'd10;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 6'd26;
  localparam logic                AA_RST     = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACTOR = 2'd0,
    CFG_RADIUS = 2'd1,
    CFG_AA     = 2'd2
  } cfg_reg_t;

  // Request actions
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic                          action;
    logic [COEF_IDX_W-1:0]         coef_index;
    logic [COEF_BITS-1:0]          coef_value;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_record;
  } gdf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last_of_run;
    logic                          record_done;
  } gdf_out_t;

  // Control that travels alongside one tap through the MAC pipe
  typedef struct packed {
    logic valid;
    logic last;
    logic ok;
    logic bypass;
  } mac_ctl_t;

endpackage

FILE: rtl/gaussian_decimating_fir_core.sv
// Gaussian antialiased decimator: one request per accepted item, results on a skid register.
// A sample is not accepted until all outputs it yields, in filter mode or in bypass, are
// emitted; the shared MAC takes one tap per cycle.
// Synchronous reset clears control, configuration and record position; memories are
// not cleared (out-of-record window entries are masked by position).
`include "gaussian_decimating_fir_core_assert.svh"
module gaussian_decimating_fir_core #(
  parameter int MAX_RADIUS = gdf_pkg::DEF_MAX_RADIUS,
  parameter int MAX_FACTOR = gdf_pkg::DEF_MAX_FACTOR
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gdf_pkg::gdf_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gdf_pkg::gdf_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [gdf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gdf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SB         = gdf_pkg::SAMPLE_BITS;
  localparam int CB         = gdf_pkg::COEF_BITS;
  localparam int POS_W      = gdf_pkg::POS_W;
  localparam int REC_W      = gdf_pkg::REC_W;
  localparam int COEF_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int TAP_W      = $clog2(COEF_DEPTH);
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int FAC_W      = $clog2(MAX_FACTOR + 1);
  localparam int DLY_W      = (RAD_W > FAC_W) ? RAD_W : FAC_W;
  localparam int ACC_W      = SB + CB + 1 + TAP_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_ISSUE = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [gdf_pkg::FACTOR_W-1:0] factor;
  logic [gdf_pkg::RADIUS_W-1:0] radius;
  logic                         aa_enable;

  logic signed [SB-1:0] window [gdf_pkg::WIN_DEPTH];
  logic [CB-1:0]        coef_mem [COEF_DEPTH];

  logic [REC_W-1:0]         record_position;
  logic [REC_W-1:0]         next_center;
  logic [REC_W-1:0]         p_l;
  logic                     eor_l;
  logic [FAC_W-1:0]         f_l;
  logic [RAD_W-1:0]         r_l;
  logic                     aa_l;
  logic [DLY_W-1:0]         dly_l;
  logic                     phase_main;
  logic [gdf_pkg::CNT_W-1:0] n_res;
  logic [POS_W-1:0]         base;
  logic [TAP_W-1:0]         k;
  logic signed [SB-1:0]     held_sample;
  logic                     held_valid;

  logic [FAC_W-1:0] f_sat;
  logic [RAD_W-1:0] r_sat;
  logic [FAC_W-1:0] f_m1;
  logic [DLY_W-1:0] dly_sat;

  logic             acc_in;
  logic             smp_acc;
  logic             load_acc;
  logic             main_cond;
  logic             flush_cond;
  logic             more_main;
  logic             more;
  logic             go;
  logic             emit;
  logic [POS_W-1:0] p_ext;
  logic [POS_W-1:0] pos;
  logic             pos_ok;
  logic             last_tap;
  logic             issue;

  logic signed [SB-1:0] rd_sample;
  logic [CB-1:0]        rd_coef;
  gdf_pkg::mac_ctl_t    ctl_a;
  logic                 mac_clear;
  logic                 mac_done;
  logic signed [SB-1:0] mac_result;

  assign in_ready = (state == S_IDLE);
  assign acc_in   = in_valid & in_ready;
  assign smp_acc  = acc_in & (in_data.action == gdf_pkg::ACT_SAMPLE);
  assign load_acc = acc_in & (in_data.action == gdf_pkg::ACT_LOAD);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      factor    <= gdf_pkg::FACTOR_RST;
      radius    <= gdf_pkg::RADIUS_RST;
      aa_enable <= gdf_pkg::AA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gdf_pkg::CFG_FACTOR: factor    <= cfg_data[gdf_pkg::FACTOR_W-1:0];
        gdf_pkg::CFG_RADIUS: radius    <= cfg_data[gdf_pkg::RADIUS_W-1:0];
        gdf_pkg::CFG_AA:     aa_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective factor, radius and emission delay for this sample
  always_comb begin
    if (factor == '0) begin
      f_sat = FAC_W'(1);
    end else if (32'(factor) > MAX_FACTOR) begin
      f_sat = FAC_W'(MAX_FACTOR);
    end else begin
      f_sat = FAC_W'(factor);
    end
    if (32'(radius) > MAX_RADIUS) begin
      r_sat = RAD_W'(MAX_RADIUS);
    end else begin
      r_sat = RAD_W'(radius);
    end
    f_m1 = f_sat - FAC_W'(1);
    if (aa_enable && (DLY_W'(r_sat) > DLY_W'(f_m1))) begin
      dly_sat = DLY_W'(r_sat);
    end else begin
      dly_sat = DLY_W'(f_m1);
    end
  end

  // Emission decisions
  assign p_ext      = POS_W'(p_l);
  assign main_cond  = (POS_W'(next_center) + POS_W'(dly_l)) <= p_ext;
  assign flush_cond = (POS_W'(next_center) + POS_W'(f_l)) <= (p_ext + POS_W'(1));
  assign more_main  = phase_main & main_cond;
  assign more       = (n_res < gdf_pkg::CNT_W'(gdf_pkg::RESULT_CAP)) &
                      (more_main | (eor_l & flush_cond));
  assign go         = ~held_valid | ~out_valid | out_ready;
  assign emit       = (state == S_CHECK) & go & held_valid;

  // Tap address and record bounds check
  assign pos      = base + POS_W'(k);
  assign pos_ok   = ~pos[POS_W-1] && (pos <= p_ext) &&
                    ((p_ext - pos) < POS_W'(gdf_pkg::WIN_DEPTH));
  assign last_tap = ~aa_l || (k == (TAP_W'(r_l) << 1));
  assign issue    = (state == S_ISSUE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (smp_acc) state_next = S_CHECK;
      S_CHECK: if (go) state_next = more ? S_ISSUE : S_IDLE;
      S_ISSUE: if (last_tap) state_next = S_WAIT;
      S_WAIT:  if (mac_done) state_next = S_CHECK;
      default: state_next = S_IDLE;
    endcase
  end

  // Window and coefficient memories
  always_ff @(posedge clk) begin
    if (smp_acc) begin
      window[record_position[gdf_pkg::WIN_AW-1:0]] <= in_data.sample_in;
    end
    if (load_acc && (32'(in_data.coef_index) < COEF_DEPTH)) begin
      coef_mem[TAP_W'(in_data.coef_index)] <= in_data.coef_value;
    end
    rd_sample <= window[pos[gdf_pkg::WIN_AW-1:0]];
    rd_coef   <= coef_mem[k];
  end

  // Sequencer and record state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      record_position <= '0;
      next_center     <= '0;
      held_valid      <= 1'b0;
      out_valid       <= 1'b0;
      ctl_a           <= '0;
      n_res           <= '0;
      phase_main      <= 1'b1;
      k               <= '0;
    end else begin
      state <= state_next;
      ctl_a <= '{valid: issue, last: last_tap, ok: pos_ok, bypass: ~aa_l};
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (smp_acc) begin
            p_l             <= record_position;
            eor_l           <= in_data.end_of_record;
            f_l             <= f_sat;
            r_l             <= r_sat;
            aa_l            <= aa_enable;
            dly_l           <= dly_sat;
            phase_main      <= 1'b1;
            n_res           <= '0;
            record_position <= record_position + REC_W'(1);
          end
        end
        S_CHECK: begin
          if (go) begin
            if (held_valid) begin
              out_data.sample_out      <= held_sample;
              out_data.last_of_run     <= ~more;
              out_data.record_done     <= eor_l & ~more;
              held_valid               <= 1'b0;
            end
            if (!more_main) begin
              phase_main <= 1'b0;
            end
            if (more) begin
              base        <= aa_l ? POS_W'(next_center) - POS_W'(r_l)
                                  : POS_W'(next_center);
              next_center <= next_center + REC_W'(f_l);
              n_res       <= n_res + gdf_pkg::CNT_W'(1);
              k           <= '0;
            end else if (eor_l) begin
              record_position <= '0;
              next_center     <= '0;
            end
          end
        end
        S_ISSUE: begin
          k <= k + TAP_W'(1);
        end
        S_WAIT: begin
          if (mac_done) begin
            held_sample <= mac_result;
            held_valid  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign mac_clear = (state == S_CHECK) & go & more;

  gdf_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (mac_clear),
    .ctl    (ctl_a),
    .sample (rd_sample),
    .coef   (rd_coef),
    .done   (mac_done),
    .result (mac_result)
  );

  `GDF_ASSERT_IMP(a_issue_no_held, clk, rst, state == S_ISSUE, !held_valid)
  `GDF_ASSERT_IMP(a_cap, clk, rst, 1'b1, n_res <= gdf_pkg::CNT_W'(gdf_pkg::RESULT_CAP))
  `GDF_ASSERT_IMP(a_done_in_wait, clk, rst, mac_done, state == S_WAIT)
  `GDF_ASSERT_NXT(a_sample_check, clk, rst, smp_acc, state == S_CHECK)

endmodule

FILE: rtl/gdf_mac.sv
// Shared multiply-accumulate unit with rounding and saturation outside bypass.
// Depends on gdf_pkg.
module gdf_mac #(
  parameter int ACC_W = 42
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   clear,
  input  gdf_pkg::mac_ctl_t                      ctl,
  input  logic signed [gdf_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [gdf_pkg::COEF_BITS-1:0]          coef,
  output logic                                   done,
  output logic signed [gdf_pkg::SAMPLE_BITS-1:0] result
);

  localparam int SB     = gdf_pkg::SAMPLE_BITS;
  localparam int CB     = gdf_pkg::COEF_BITS;
  localparam int PROD_W = SB + CB + 1;
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) << (CB - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SB - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  gdf_pkg::mac_ctl_t        ctl_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     bypass_c;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  q;

  // Product stage: out-of-record taps contribute zero
  always_ff @(posedge clk) begin
    if (!ctl.ok) begin
      prod <= '0;
    end else if (ctl.bypass) begin
      prod <= PROD_W'(sample);
    end else begin
      prod <= sample * $signed({1'b0, coef});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b <= '0;
      done  <= 1'b0;
    end else begin
      ctl_b <= ctl;
      done  <= ctl_b.valid & ctl_b.last;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (ctl_b.valid) begin
      acc      <= acc + ACC_W'(prod);
      bypass_c <= ctl_b.bypass;
    end
  end

  // Round half up, then saturate
  assign rnd = acc + RND;
  assign q   = rnd >>> CB;

  always_comb begin
    if (bypass_c) begin
      result = acc[SB-1:0];
    end else if (q > SAT_HI) begin
      result = SAT_HI[SB-1:0];
    end else if (q < SAT_LO) begin
      result = SAT_LO[SB-1:0];
    end else begin
      result = q[SB-1:0];
    end
  end

endmodule
